### rtl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ASCII block
// Holds the controller state type, the command and status bundles passed
// between controller and datapath, and the digit count helper.
// ----------------------------------------------------------------------------
package bda_pkg;

  // Upper two bits of an ASCII digit ('0' is 6'b11_0000 in the low six bits)
  localparam logic [1:0] AsciiDigitHi = 2'b11;

  // Largest decimal digit value
  localparam logic [3:0] DigitMax = 4'd9;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StConvert,
    StSkip,
    StEmit
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture a new value, clear the BCD register
    logic dabble;  // one add-3 and shift step
    logic shift;   // drop the top digit
  } bda_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic bits_last;  // the final dabble step is in progress
    logic top_zero;   // top digit is zero
    logic one_left;   // only the units digit remains
  } bda_status_t;

  // Number of decimal digits of 2^bits - 1, evaluated at elaboration
  function automatic int unsigned bda_dec_digits(input int unsigned bits);
    longint unsigned maxv;
    int unsigned n;
    maxv = (64'd1 << bits) - 64'd1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (maxv != 64'd0) begin
        maxv = maxv / 10;
        n++;
      end
    end
    if (n == 0) begin
      n = 1;
    end
    return n;
  endfunction

endpackage

### rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII digit stream
// Converts one VALUE_BITS-bit value per request into its decimal digits as
// ASCII characters, most significant first, leading zeros suppressed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel value_valid_i / value_ready_o carries value_i. Ready is
//   high only while the block is idle; one value is worked at a time.
//   Output channel digit_valid_o / digit_ready_i carries digit_char_o
//   ('0'..'9' in six bits) and last_digit_o, high on the units digit.
//   Zero yields a single '0' with last_digit_o set.
// Sequence:
//   After acceptance the double dabble loop runs one bit per cycle over all
//   VALUE_BITS bits. Leading zeros are then dropped at one per cycle, a
//   further step finds the leading digit, and each digit is shown until it
//   is taken. Ready returns the cycle after the last digit leaves, so one
//   value is finished before another is accepted.
// Reset and stall:
//   Reset returns the controller to idle and drops any run in progress.
//   A stalled receiver holds the current digit steady until it is taken.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  value_valid_i,
  output logic                  value_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  digit_valid_o,
  input  logic                  digit_ready_i,
  output logic [5:0]            digit_char_o,
  output logic                  last_digit_o
);
  import bda_pkg::*;

  bda_cmd_t    cmd;
  bda_status_t status;

  // Sequencing
  bda_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_valid_i (value_valid_i),
    .value_ready_o (value_ready_o),
    .digit_valid_o (digit_valid_o),
    .digit_ready_i (digit_ready_i),
    .last_digit_o  (last_digit_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Conversion registers
  bda_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (value_i),
    .status_o     (status),
    .digit_char_o (digit_char_o)
  );

endmodule

### rtl/bda_datapath.sv
// ----------------------------------------------------------------------------
// bda_datapath: double dabble conversion and digit shift-out
// Holds the binary shift register, the BCD register, the step counter and
// the count of digits still to leave.
// ----------------------------------------------------------------------------
module bda_datapath #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bda_pkg::bda_cmd_t      cmd_i,
  input  logic [VALUE_BITS-1:0]  value_i,
  output bda_pkg::bda_status_t   status_o,
  output logic [5:0]             digit_char_o
);
  import bda_pkg::*;

  localparam int unsigned NumDigits = bda_dec_digits(VALUE_BITS);
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CntW      = $clog2(VALUE_BITS);
  localparam int unsigned LeftW     = $clog2(NumDigits + 1);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [BcdW-1:0]       bcd_adj;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [LeftW-1:0]      left_q, left_d;

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] > 4'd4) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Next values of the datapath registers
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    left_d = left_q;
    if (cmd_i.load) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = '0;
      left_d = LeftW'(NumDigits);
    end else if (cmd_i.dabble) begin
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[VALUE_BITS-1]};
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.shift) begin
      bcd_d  = {bcd_q[BcdW-5:0], 4'd0};
      left_d = left_q - 1'b1;
    end
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      left_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      left_q <= left_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o.bits_last = (cnt_q == CntW'(VALUE_BITS - 1));
  assign status_o.top_zero  = (bcd_q[BcdW-1 -: 4] == 4'd0);
  assign status_o.one_left  = (left_q == LeftW'(1));

  assign digit_char_o = {AsciiDigitHi, bcd_q[BcdW-1 -: 4]};

endmodule

### rtl/bda_ctrl.sv
// ----------------------------------------------------------------------------
// bda_ctrl: sequencing for the binary to decimal ASCII block
// Steps through conversion, leading zero skip and digit emission, and runs
// the request handshakes on both channels.
// ----------------------------------------------------------------------------
module bda_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  value_valid_i,
  output logic                  value_ready_o,
  output logic                  digit_valid_o,
  input  logic                  digit_ready_i,
  output logic                  last_digit_o,
  input  bda_pkg::bda_status_t  status_i,
  output bda_pkg::bda_cmd_t     cmd_o
);
  import bda_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (value_valid_i) begin
          state_d = StConvert;
        end
      end
      StConvert: begin
        if (status_i.bits_last) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (!status_i.top_zero || status_i.one_left) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (digit_ready_i && status_i.one_left) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    value_ready_o = 1'b0;
    digit_valid_o = 1'b0;
    last_digit_o  = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      StIdle: begin
        value_ready_o = 1'b1;
        cmd_o.load    = value_valid_i;
      end
      StConvert: begin
        cmd_o.dabble = 1'b1;
      end
      StSkip: begin
        // drop a leading zero, but always keep the units digit
        cmd_o.shift = status_i.top_zero && !status_i.one_left;
      end
      StEmit: begin
        digit_valid_o = 1'b1;
        last_digit_o  = status_i.one_left;
        cmd_o.shift   = digit_ready_i;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker: port-level checks for binary_to_decimal_ascii
// Watches both channels and flags digit, sequencing and stall violations.
// ----------------------------------------------------------------------------
module bda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       value_valid_i,
  input logic       value_ready_o,
  input logic       digit_valid_o,
  input logic       digit_ready_i,
  input logic [5:0] digit_char_o,
  input logic       last_digit_o
);
  import bda_pkg::*;

  // Hold a stalled digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o && !digit_ready_i |=>
      digit_valid_o && $stable(digit_char_o) && $stable(last_digit_o))
    else $error("stalled digit changed or dropped");

  // Every digit is an ASCII decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |->
      digit_char_o[5:4] == AsciiDigitHi && digit_char_o[3:0] <= DigitMax)
    else $error("digit outside '0'..'9'");

  // Never take a request while digits are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_ready_o |-> !digit_valid_o)
    else $error("ready while a digit is shown");

  // A taken request starts conversion, not output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_valid_i && value_ready_o |=> !value_ready_o && !digit_valid_o)
    else $error("no conversion after request");

  // The last digit ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o && digit_ready_i && last_digit_o |=>
      value_ready_o && !digit_valid_o)
    else $error("block not idle after last digit");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .value_valid_i (value_valid_i),
  .value_ready_o (value_ready_o),
  .digit_valid_o (digit_valid_o),
  .digit_ready_i (digit_ready_i),
  .digit_char_o  (digit_char_o),
  .last_digit_o  (last_digit_o)
);
